@@ rtl/sqosc_pkg.sv @@
// Shared types and constants for the pulse oscillator with linear envelope.
`default_nettype none
package sqosc_pkg;

   // fixed field widths
   localparam int PER_W = 13;   // period and rise registers
   localparam int VOL_W = 15;   // volume and gain
   localparam int LEN_W = 24;   // duration, attack, release, note position
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = LEN_W;
   localparam int PROD_W = VOL_W + LEN_W;
   localparam int STEP_W = $clog2(VOL_W + 1);

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PERIOD  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RISE    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_VOLUME  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DUR     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ATTACK  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_RELEASE = 3'd5;

   // register reset values
   localparam logic [PER_W-1:0] PERIOD_RST = 13'd100;
   localparam logic [PER_W-1:0] RISE_RST   = 13'd50;
   localparam logic [LEN_W-1:0] DUR_RST    = 24'd1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_WRITE
   } state_type;

   typedef enum logic [1:0] {
      GM_ZERO,
      GM_FULL,
      GM_ATTACK,
      GM_RELEASE
   } gain_mode_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage
`default_nettype wire

@@ rtl/sqosc_div.sv @@
// Serial restoring divider, one quotient bit per cycle, quotient known to fit VOL_W bits.
`default_nettype none
module sqosc_div (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [sqosc_pkg::PROD_W-1:0] dividend,
   input  wire logic [sqosc_pkg::LEN_W-1:0]  divisor,
   output      logic [sqosc_pkg::VOL_W-1:0]  quotient,
   output      sqosc_pkg::div_status_type    status
);
   import sqosc_pkg::*;

   logic [PROD_W-1:0] acc_ff, acc_in;       // {remainder, dividend bits / quotient bits}
   logic [LEN_W-1:0]  den_ff, den_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;

   logic [LEN_W+1:0]  diff;
   logic              ge;

   // trial subtract of the divisor from the remainder with the next bit shifted in
   assign diff = {1'b0, acc_ff[PROD_W-1:VOL_W-1]} - {2'b00, den_ff};
   assign ge   = ~diff[LEN_W+1];

   always_comb begin
      acc_in  = acc_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         acc_in  = dividend;
         den_in  = divisor;
         cnt_in  = STEP_W'(VOL_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = {(ge ? diff[LEN_W-1:0] : acc_ff[PROD_W-2:VOL_W-1]),
                   acc_ff[VOL_W-2:0], ge};
         cnt_in = cnt_ff - STEP_W'(1);
         if (cnt_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      den_ff <= den_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quotient    = acc_ff[VOL_W-1:0];
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule
`default_nettype wire

@@ rtl/square_oscillator_linear_envelope.sv @@
// Pulse-wave note oscillator with linear attack/release envelope, mixed into a sample stream.
//
// req_ carries one existing mix sample per word; rsp_ returns the sample with the
// enveloped pulse added (wrapped to SAMPLE_WIDTH bits) and tlast on the note's final
// sample, after which the phase and note position restart.
// csr_ writes the six note registers by index: period, rise, volume, duration, attack,
// release. The user writes only with no word in flight; the block does not enforce it.
// One word is worked on at a time; req_tready is high only when the sequencer is idle.
// A word needing no division (pulse low, or full volume) goes from idle straight to
// the write step; during attack or release it first passes the multiply and divide
// steps, which use one 39 x 24 bit serial divider producing one quotient bit per cycle
// (15 steps) on the 15 x 24 product, which the divider registers as it starts.
// The result sits in an output register, so the next word is accepted while it waits;
// if the receiver stalls, that next word finishes its arithmetic and then waits until
// the output register is taken.
// Synchronous reset clears the counters, returns the registers to their defaults
// (period 100, rise 50, volume 0, duration 1, attack and release off) and empties
// the output register.
`default_nettype none
module square_oscillator_linear_envelope #(
   parameter int MAX_PERIOD   = 4096,
   parameter int SAMPLE_WIDTH = 16
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_tvalid,
   output      logic                                   req_tready,
   input  wire logic [((SAMPLE_WIDTH+7)/8)*8-1:0]      req_tdata,  // mix_in
   output      logic                                   rsp_tvalid,
   input  wire logic                                   rsp_tready,
   output      logic [((SAMPLE_WIDTH+7)/8)*8-1:0]      rsp_tdata,  // mix_out
   output      logic                                   rsp_tlast,  // last
   input  wire logic                                   csr_we,
   input  wire logic [sqosc_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire logic [sqosc_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import sqosc_pkg::*;

   localparam int TDW = ((SAMPLE_WIDTH + 7) / 8) * 8;
   localparam int PW  = $clog2(MAX_PERIOD);
   localparam int CW  = (PW + 1 > PER_W) ? PW + 1 : PER_W;
   localparam int GW  = (SAMPLE_WIDTH > VOL_W) ? SAMPLE_WIDTH : VOL_W;

   // note registers
   logic [PER_W-1:0] period_ff, rise_ff;
   logic [VOL_W-1:0] volume_ff;
   logic [LEN_W-1:0] dur_ff, attack_ff, release_ff;

   // running state
   state_type         state_ff, state_in;
   logic [PW-1:0]     phase_ff, phase_in;
   logic [LEN_W-1:0]  index_ff, index_in;
   gain_mode_type     mode_ff, mode_in;
   logic [LEN_W-1:0]  num_ff, num_in;
   logic [LEN_W-1:0]  den_ff, den_in;
   logic              fin_ff, fin_in;
   logic [SAMPLE_WIDTH-1:0] mix_ff, mix_in;
   logic [VOL_W-1:0]  gain_ff, gain_in;

   // output register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_WIDTH-1:0] rsp_data_ff, rsp_data_in;
   logic                    rsp_last_ff, rsp_last_in;

   // divider
   logic                 div_start;
   logic [PROD_W-1:0]    product;
   logic [VOL_W-1:0]     quotient;
   div_status_type       div_st;

   // per-word decode
   logic              accept;
   logic [CW-1:0]     per_eff;
   logic [LEN_W-1:0]  dur_eff;
   logic              fin;
   logic [LEN_W-1:0]  i_eff;
   logic              pulse_on;
   logic [CW-1:0]     phase_inc;
   logic              out_free;
   logic [GW-1:0]     sum_wide;

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff  <= PERIOD_RST;
         rise_ff    <= RISE_RST;
         volume_ff  <= '0;
         dur_ff     <= DUR_RST;
         attack_ff  <= '0;
         release_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_PERIOD:  period_ff  <= csr_wdata[PER_W-1:0];
            CSR_RISE:    rise_ff    <= csr_wdata[PER_W-1:0];
            CSR_VOLUME:  volume_ff  <= csr_wdata[VOL_W-1:0];
            CSR_DUR:     dur_ff     <= csr_wdata[LEN_W-1:0];
            CSR_ATTACK:  attack_ff  <= csr_wdata[LEN_W-1:0];
            CSR_RELEASE: release_ff <= csr_wdata[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   assign accept = req_tvalid && req_tready;

   // period clamped to 1..MAX_PERIOD, duration forced to at least 1
   always_comb begin
      per_eff = CW'(period_ff);
      if (period_ff == '0) per_eff = CW'(1);
      else if (CW'(period_ff) > CW'(MAX_PERIOD)) per_eff = CW'(MAX_PERIOD);
      dur_eff = (dur_ff == '0) ? LEN_W'(1) : dur_ff;
   end

   assign fin       = ({1'b0, index_ff} + (LEN_W+1)'(1)) >= {1'b0, dur_eff};
   assign i_eff     = fin ? dur_eff - LEN_W'(1) : index_ff;
   assign pulse_on  = CW'(phase_ff) < CW'(rise_ff);
   assign phase_inc = CW'(phase_ff) + CW'(1);
   assign out_free  = !rsp_valid_ff || rsp_tready;

   assign product = PROD_W'(volume_ff) * PROD_W'(num_ff);

   sqosc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (product),
      .divisor  (den_ff),
      .quotient (quotient),
      .status   (div_st)
   );

   assign sum_wide = GW'(mix_ff) + GW'(gain_ff);

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      index_in     = index_ff;
      mode_in      = mode_ff;
      num_in       = num_ff;
      den_in       = den_ff;
      fin_in       = fin_ff;
      mix_in       = mix_ff;
      gain_in      = gain_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      req_tready   = 1'b0;
      div_start    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               mix_in = req_tdata[SAMPLE_WIDTH-1:0];
               fin_in = fin;
               if (!pulse_on) begin
                  mode_in = GM_ZERO;
               end else if (i_eff < attack_ff) begin
                  mode_in = GM_ATTACK;
               end else if (release_ff <= dur_eff && i_eff > dur_eff - release_ff) begin
                  mode_in = GM_RELEASE;
               end else begin
                  mode_in = GM_FULL;
               end
               num_in = (mode_in == GM_RELEASE) ? dur_eff - i_eff : i_eff;
               den_in = (mode_in == GM_RELEASE) ? release_ff : attack_ff;
               gain_in = (mode_in == GM_FULL) ? volume_ff : '0;
               state_in = (mode_in == GM_ATTACK || mode_in == GM_RELEASE) ? ST_MUL
                                                                           : ST_WRITE;
               // counters advance as the word is taken
               if (fin) begin
                  index_in = '0;
                  phase_in = '0;
               end else begin
                  index_in = i_eff + LEN_W'(1);
                  phase_in = (phase_inc >= per_eff) ? '0 : phase_inc[PW-1:0];
               end
            end
         end
         ST_MUL: begin
            div_start = 1'b1;
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            if (div_st.done) begin
               gain_in  = quotient;
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = sum_wide[SAMPLE_WIDTH-1:0];
               rsp_last_in  = fin_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      num_ff      <= num_in;
      den_ff      <= den_in;
      fin_ff      <= fin_in;
      mix_ff      <= mix_in;
      gain_ff     <= gain_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= '0;
         index_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         index_ff     <= index_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = TDW'(rsp_data_ff);
   assign rsp_tlast  = rsp_last_ff;

   // a new result only ever comes out of the write step
   a_rsp_from_write: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_WRITE))
      else $error("result appeared outside the write step");

   // the divider only runs while the sequencer waits on it
   a_div_owned: assert property (@(posedge clock) disable iff (reset)
      (div_st.busy || div_st.done) |-> state_ff == ST_DIV)
      else $error("divider active outside the divide step");

   // envelope gain never exceeds the volume
   a_gain_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WRITE |-> gain_ff <= volume_ff)
      else $error("envelope gain above volume");

   // a word is only taken with the divider idle
   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      accept |-> !div_st.busy && state_ff == ST_IDLE)
      else $error("word accepted while busy");

endmodule
`default_nettype wire
